// ===== sv/pngunf_pkg.sv =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared payload types, filter codes and the control word that travels from
// the front end to the reconstruction back end.
// ----------------------------------------------------------------------------
`default_nettype none

package pngunf_pkg;

    // PNG filter-type codes.
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_kind_t;

    // Largest legal filter-type byte.
    localparam logic [7:0] FILT_CODE_MAX = 8'd4;

    // Width of the image_width configuration register.
    localparam int CFG_WIDTH_W = 12;

    // Entries in the queue between front and back end.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] filtered_byte;
        logic       start_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [7:0] recon_byte;
        logic       last_in_row;
        logic       bad_filter;
    } out_item_t;

    // One classified byte waiting for reconstruction.
    typedef struct packed {
        logic [7:0] data;
        filt_kind_t kind;
        logic       first_row;
        logic       first_col;
        logic       last;
        logic       bad;
    } unf_ctl_t;

endpackage

`default_nettype wire

// ===== sv/pngunf_front.sv =====
// ----------------------------------------------------------------------------
// PNG unfilter front end
// Holds the width register, tracks row framing and classifies each byte as a
// filter-type byte, a bad filter type or a sample byte with its store address.
// ----------------------------------------------------------------------------
`default_nettype none

module pngunf_front #(
    parameter int MAX_WIDTH       = 2048,
    parameter int BYTES_PER_PIXEL = 3,
    parameter int ADDR_W          = 13
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [pngunf_pkg::CFG_WIDTH_W-1:0]   cfg_width,
    input  wire logic                                 in_fire,
    input  wire pngunf_pkg::in_item_t                 in_data,
    output logic                                      push_valid,
    output pngunf_pkg::unf_ctl_t                      push_ctl,
    output logic [ADDR_W-1:0]                         push_addr
);

    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (COL_W > pngunf_pkg::CFG_WIDTH_W) ? COL_W
                                                            : pngunf_pkg::CFG_WIDTH_W;
    localparam int CH_W  = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1;

    logic [COL_W-1:0]       width_reg, width_next;
    logic [CMP_W-1:0]       cfg_ext;
    logic                   halted_reg, halted_next;
    logic                   awaiting_reg, awaiting_next;
    logic                   first_row_reg, first_row_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [CH_W-1:0]        ch_reg, ch_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    pngunf_pkg::filt_kind_t kind_reg, kind_next;
    logic                   row_end;

    // Width 0 acts as 1, anything above the store size acts as MAX_WIDTH.
    assign cfg_ext = CMP_W'(cfg_width);
    always_comb begin
        width_next = width_reg;
        if (cfg_we) begin
            if (cfg_ext == '0) begin
                width_next = COL_W'(1);
            end else if (cfg_ext > CMP_W'(MAX_WIDTH)) begin
                width_next = COL_W'(MAX_WIDTH);
            end else begin
                width_next = COL_W'(cfg_ext);
            end
        end
    end

    assign row_end = ({1'b0, col_reg} + (COL_W + 1)'(1)) >= {1'b0, width_reg};

    always_comb begin
        halted_next    = halted_reg;
        awaiting_next  = awaiting_reg;
        first_row_next = first_row_reg;
        col_next       = col_reg;
        ch_next        = ch_reg;
        addr_next      = addr_reg;
        kind_next      = kind_reg;
        push_valid     = 1'b0;
        push_ctl       = '0;
        push_addr      = addr_reg;
        if (in_fire) begin
            // A frame start restarts framing even in the middle of a row.
            if (in_data.start_of_frame) begin
                halted_next    = 1'b0;
                awaiting_next  = 1'b1;
                first_row_next = 1'b1;
                col_next       = '0;
                ch_next        = '0;
                addr_next      = '0;
            end
            if (!halted_next) begin
                if (awaiting_next) begin
                    if (in_data.filtered_byte > pngunf_pkg::FILT_CODE_MAX) begin
                        halted_next  = 1'b1;
                        push_valid   = 1'b1;
                        push_ctl.bad = 1'b1;
                    end else begin
                        kind_next     = pngunf_pkg::filt_kind_t'(in_data.filtered_byte[2:0]);
                        awaiting_next = 1'b0;
                        col_next      = '0;
                        ch_next       = '0;
                        addr_next     = '0;
                    end
                end else begin
                    push_valid         = 1'b1;
                    push_ctl.data      = in_data.filtered_byte;
                    push_ctl.kind      = kind_reg;
                    push_ctl.first_row = first_row_reg;
                    push_ctl.first_col = (col_reg == '0);
                    push_ctl.last      = (ch_reg == CH_W'(BYTES_PER_PIXEL - 1)) && row_end;
                    addr_next          = addr_reg + ADDR_W'(1);
                    if (ch_reg == CH_W'(BYTES_PER_PIXEL - 1)) begin
                        ch_next = '0;
                        if (row_end) begin
                            col_next       = '0;
                            awaiting_next  = 1'b1;
                            first_row_next = 1'b0;
                        end else begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end else begin
                        ch_next = ch_reg + CH_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= COL_W'(1);
            halted_reg    <= 1'b0;
            awaiting_reg  <= 1'b1;
            first_row_reg <= 1'b1;
            col_reg       <= '0;
            ch_reg        <= '0;
            addr_reg      <= '0;
            kind_reg      <= pngunf_pkg::FILT_NONE;
        end else begin
            width_reg     <= width_next;
            halted_reg    <= halted_next;
            awaiting_reg  <= awaiting_next;
            first_row_reg <= first_row_next;
            col_reg       <= col_next;
            ch_reg        <= ch_next;
            addr_reg      <= addr_next;
            kind_reg      <= kind_next;
        end
    end

`ifndef ASSERT_OFF
    // The block only halts while it is looking for a filter-type byte.
    a_halt_awaiting: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> awaiting_reg)
        else $error("front halted outside a row start");
`endif

endmodule

`default_nettype wire

// ===== sv/pngunf_queue.sv =====
// ----------------------------------------------------------------------------
// PNG unfilter queue
// Short first-in first-out buffer that decouples the front end from the
// reconstruction back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pngunf_queue #(
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output logic [DATA_W-1:0]      head_data
);

    localparam int DEPTH = pngunf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue written while full");
`endif

endmodule

`default_nettype wire

// ===== sv/pngunf_back.sv =====
// ----------------------------------------------------------------------------
// PNG unfilter back end
// Reads the row above from the line store, applies the filter rule and
// registers the reconstructed byte for the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pngunf_back #(
    parameter int BYTES_PER_PIXEL = 3,
    parameter int STORE_DEPTH     = 6144,
    parameter int ADDR_W          = 13
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_valid,
    input  wire pngunf_pkg::unf_ctl_t  q_ctl,
    input  wire logic [ADDR_W-1:0]     q_addr,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output pngunf_pkg::out_item_t      m_data
);

    logic [7:0]            store_mem [STORE_DEPTH];
    logic [7:0]            rd_data_reg;
    logic                  byp_hit_reg;
    logic [7:0]            byp_data_reg;

    logic                  b_valid_reg, b_valid_next;
    pngunf_pkg::unf_ctl_t  b_ctl_reg;
    logic [ADDR_W-1:0]     b_addr_reg;

    logic [7:0]            left_line_reg [BYTES_PER_PIXEL];
    logic [7:0]            ul_line_reg [BYTES_PER_PIXEL];

    logic                  out_valid_reg, out_valid_next;
    pngunf_pkg::out_item_t out_data_reg;

    logic                  b_fire;
    logic                  load;
    logic                  we;
    logic [7:0]            a_val, b_val, c_val;
    logic [8:0]            avg_sum;
    logic [7:0]            pred;
    logic [7:0]            recon;

    function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [10:0] p;
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [10:0]        pa;
        logic [10:0]        pb;
        logic [10:0]        pc;
        p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
        da = p - $signed({3'b000, a});
        db = p - $signed({3'b000, b});
        dc = p - $signed({3'b000, c});
        pa = (da < 0) ? 11'(-da) : 11'(da);
        pb = (db < 0) ? 11'(-db) : 11'(db);
        pc = (dc < 0) ? 11'(-dc) : 11'(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

    assign b_fire = b_valid_reg && (!out_valid_reg || m_ready);
    assign load   = q_valid && (!b_valid_reg || b_fire);
    assign q_pop  = load;
    assign we     = b_fire && !b_ctl_reg.bad;

    // Left and upper-left bytes come from the same channel one pixel back.
    assign a_val = b_ctl_reg.first_col ? 8'd0 : left_line_reg[BYTES_PER_PIXEL-1];
    assign c_val = b_ctl_reg.first_col ? 8'd0 : ul_line_reg[BYTES_PER_PIXEL-1];
    assign b_val = b_ctl_reg.first_row ? 8'd0 : (byp_hit_reg ? byp_data_reg : rd_data_reg);
    assign avg_sum = {1'b0, a_val} + {1'b0, b_val};

    always_comb begin
        case (b_ctl_reg.kind)
            pngunf_pkg::FILT_NONE:  pred = 8'd0;
            pngunf_pkg::FILT_SUB:   pred = a_val;
            pngunf_pkg::FILT_UP:    pred = b_val;
            pngunf_pkg::FILT_AVG:   pred = avg_sum[8:1];
            pngunf_pkg::FILT_PAETH: pred = paeth_pred(a_val, b_val, c_val);
            default:                pred = 8'd0;
        endcase
    end

    assign recon = b_ctl_reg.data + pred;

    always_comb begin
        b_valid_next = b_valid_reg;
        if (load) begin
            b_valid_next = 1'b1;
        end else if (b_fire) begin
            b_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (b_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Line store: one write and one registered read per cycle. A read of the
    // address being written in the same cycle takes the new byte by bypass.
    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[b_addr_reg] <= recon;
        end
        if (load) begin
            rd_data_reg  <= store_mem[q_addr];
            byp_data_reg <= recon;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_hit_reg   <= 1'b0;
        end else begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            if (load) begin
                byp_hit_reg <= we && (b_addr_reg == q_addr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            b_ctl_reg  <= q_ctl;
            b_addr_reg <= q_addr;
        end
        if (we) begin
            left_line_reg[0] <= recon;
            ul_line_reg[0]   <= b_val;
            for (int i = 1; i < BYTES_PER_PIXEL; i++) begin
                left_line_reg[i] <= left_line_reg[i-1];
                ul_line_reg[i]   <= ul_line_reg[i-1];
            end
        end
        if (b_fire) begin
            out_data_reg.recon_byte  <= b_ctl_reg.bad ? 8'd0 : recon;
            out_data_reg.last_in_row <= b_ctl_reg.last && !b_ctl_reg.bad;
            out_data_reg.bad_filter  <= b_ctl_reg.bad;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_bad_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.bad_filter) |->
            (out_data_reg.recon_byte == 8'd0 && !out_data_reg.last_in_row))
        else $error("bad filter result carries data");

    a_exec_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_fire) |=> (b_valid_reg && $stable(b_addr_reg)))
        else $error("execute stage lost a stalled byte");
`endif

endmodule

`default_nettype wire

// ===== sv/png_scanline_unfilter.sv =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Rebuilds 8-bit RGB sample bytes from the inflated PNG stream.
// ----------------------------------------------------------------------------
// Usage: bytes of the inflated stream enter on s_valid/s_ready/s_data, one
// byte per transfer; start_of_frame marks the first filter-type byte of an
// image. Each sample byte gives one transfer on m_valid/m_ready/m_data with
// last_in_row on the final byte of a row. A filter type above 4 gives one
// transfer with bad_filter set, and the block drops bytes until the next
// frame start. image_width is written on cfg_valid/cfg_data while idle.
// A sample byte passes the queue, the execute stage and the output
// register before it shows on m_valid. Throughput: one byte per cycle
// while m_ready stays high, set by the line store, which does one read
// and one write per cycle. A four-entry queue sits between the framing
// front end and the reconstruction back end; when the receiver stalls
// the output register holds, the queue fills and s_ready drops.
// Reset clears the control state and leaves the block waiting for the
// filter-type byte of a first row, width 1. The line store is not cleared;
// the row above the first row reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module png_scanline_unfilter #(
    parameter int MAX_WIDTH       = 2048,
    parameter int BYTES_PER_PIXEL = 3
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [pngunf_pkg::CFG_WIDTH_W-1:0]   cfg_data,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire pngunf_pkg::in_item_t                 s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output pngunf_pkg::out_item_t                     m_data
);

    localparam int STORE_DEPTH = MAX_WIDTH * BYTES_PER_PIXEL;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CTL_W       = $bits(pngunf_pkg::unf_ctl_t);
    localparam int QDATA_W     = ADDR_W + CTL_W;

    logic                  in_fire;
    logic                  push_valid;
    pngunf_pkg::unf_ctl_t  push_ctl;
    logic [ADDR_W-1:0]     push_addr;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_valid;
    logic [QDATA_W-1:0]    q_head;
    pngunf_pkg::unf_ctl_t  q_ctl;
    logic [ADDR_W-1:0]     q_addr;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign in_fire   = s_valid && s_ready;

    pngunf_front #(
        .MAX_WIDTH       (MAX_WIDTH),
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL),
        .ADDR_W          (ADDR_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_width  (cfg_data),
        .in_fire    (in_fire),
        .in_data    (s_data),
        .push_valid (push_valid),
        .push_ctl   (push_ctl),
        .push_addr  (push_addr)
    );

    pngunf_queue #(
        .DATA_W (QDATA_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_data  ({push_addr, push_ctl}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    assign q_addr = q_head[QDATA_W-1:CTL_W];
    assign q_ctl  = pngunf_pkg::unf_ctl_t'(q_head[CTL_W-1:0]);

    pngunf_back #(
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL),
        .STORE_DEPTH     (STORE_DEPTH),
        .ADDR_W          (ADDR_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ctl   (q_ctl),
        .q_addr  (q_addr),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_png_scanline_unfilter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Drives the inflated byte stream through a stimulus table of corner cases and
// then through random frames at several image widths, including the smallest
// and the largest, with random idle gaps on both channels and one long receiver
// hold. A behavioral predictor rebuilds every sample byte, and each result
// transfer is compared field by field against the oldest expected byte.
// ----------------------------------------------------------------------------

module tb_png_scanline_unfilter;

    localparam int MAX_W       = 2048;
    localparam int PIX_BYTES   = 3;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYC  = 12;
    localparam int SMALL_BUDGET = 50;
    localparam int CFG_W       = pngunf_pkg::CFG_WIDTH_W;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    pngunf_pkg::in_item_t   s_data;
    logic                   m_valid;
    logic                   m_ready;
    pngunf_pkg::out_item_t  m_data;

    png_scanline_unfilter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Predictor state.
    logic [7:0]             line_mem [0:MAX_W*PIX_BYTES-1];
    logic [7:0]             left_px  [PIX_BYTES];
    logic [7:0]             ul_px    [PIX_BYTES];
    int unsigned            col;
    int unsigned            chan;
    pngunf_pkg::filt_kind_t row_kind;
    bit                     want_type;
    bit                     first_row;
    bit                     halted_st;
    logic [CFG_W-1:0]       width_reg;

    pngunf_pkg::out_item_t recon_q[$];
    int unsigned err_count;
    int unsigned sent_count;
    int unsigned idle_cycles;
    bit          src_burst;
    bit          sink_burst;
    bit          hold_now;

    typedef struct {
        logic                  sof;
        logic [7:0]            code;
        bit                    typed;
        bit                    has_res;
        pngunf_pkg::out_item_t res;
    } dir_row_t;

    // Runs at the reset width of one pixel, so each row is a type byte and
    // three samples.
    dir_row_t dir_tab [25] = '{
        '{1'b0, {5'd0, pngunf_pkg::FILT_NONE},  1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, 8'hFF,                          1'b1, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        '{1'b0, 8'h00,                          1'b1, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, 8'h80,                          1'b1, 1'b1, '{8'h80, 1'b1, 1'b0}},
        '{1'b0, {5'd0, pngunf_pkg::FILT_UP},    1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, 8'h01,                          1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, 8'hFF,                          1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, 8'h80,                          1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, {5'd0, pngunf_pkg::FILT_AVG},   1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, 8'hFF,                          1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, 8'h01,                          1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, 8'h7F,                          1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, {5'd0, pngunf_pkg::FILT_PAETH}, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, 8'hFF,                          1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, 8'h00,                          1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, 8'h7F,                          1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b1, pngunf_pkg::FILT_CODE_MAX + 8'd1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
        '{1'b0, 8'h12,                          1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b1, 8'hFF,                          1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
        '{1'b1, {5'd0, pngunf_pkg::FILT_NONE},  1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, 8'h55,                          1'b1, 1'b1, '{8'h55, 1'b0, 1'b0}},
        '{1'b1, {5'd0, pngunf_pkg::FILT_PAETH}, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{1'b0, 8'h10,                          1'b1, 1'b1, '{8'h10, 1'b0, 1'b0}},
        '{1'b0, 8'h20,                          1'b1, 1'b1, '{8'h20, 1'b0, 1'b0}},
        '{1'b0, 8'h30,                          1'b1, 1'b1, '{8'h30, 1'b1, 1'b0}}
    };

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned eff_w(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_W) return MAX_W;
        return 32'(v);
    endfunction

    function automatic int unsigned paeth_pick(input int a, input int b, input int c);
        int p;
        int pa;
        int pb;
        int pc;
        p  = a + b - c;
        pa = (p > a) ? p - a : a - p;
        pb = (p > b) ? p - b : b - p;
        pc = (p > c) ? p - c : c - p;
        if (pa <= pb && pa <= pc) return a;
        if (pb <= pc) return b;
        return c;
    endfunction

    function automatic void predict_recon(input pngunf_pkg::in_item_t it, output bit has_res,
                                          output pngunf_pkg::out_item_t res);
        int unsigned w;
        int unsigned idx;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned pred;
        has_res = 1'b0;
        res     = '0;
        w       = eff_w(width_reg);
        if (it.start_of_frame) begin
            halted_st = 1'b0;
            want_type = 1'b1;
            first_row = 1'b1;
            col       = 0;
            chan      = 0;
        end
        if (halted_st) return;
        if (want_type) begin
            if (it.filtered_byte > pngunf_pkg::FILT_CODE_MAX) begin
                halted_st      = 1'b1;
                has_res        = 1'b1;
                res.bad_filter = 1'b1;
                return;
            end
            row_kind  = pngunf_pkg::filt_kind_t'(it.filtered_byte[2:0]);
            want_type = 1'b0;
            col       = 0;
            chan      = 0;
            for (int i = 0; i < PIX_BYTES; i++) begin
                left_px[i] = 8'h00;
                ul_px[i]   = 8'h00;
            end
            return;
        end
        idx = col * PIX_BYTES + chan;
        a   = left_px[chan];
        b   = first_row ? 0 : line_mem[idx];
        c   = ul_px[chan];
        case (row_kind)
            pngunf_pkg::FILT_SUB:   pred = a;
            pngunf_pkg::FILT_UP:    pred = b;
            pngunf_pkg::FILT_AVG:   pred = (a + b) >> 1;
            pngunf_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
            default:                pred = 0;
        endcase
        res.recon_byte = 8'(it.filtered_byte + pred);
        ul_px[chan]    = 8'(b);
        left_px[chan]  = res.recon_byte;
        line_mem[idx]  = res.recon_byte;
        if (chan == PIX_BYTES - 1) begin
            chan = 0;
            if (col + 1 >= w) begin
                res.last_in_row = 1'b1;
                col             = 0;
                want_type       = 1'b1;
                first_row       = 1'b0;
            end else begin
                col = col + 1;
            end
        end else begin
            chan = chan + 1;
        end
        has_res = 1'b1;
    endfunction

    // Mostly back to back, sometimes a few cycles, rarely a long pause.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rnd_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] good_type();
        return {5'd0, pngunf_pkg::filt_kind_t'($urandom_range(0, 4))};
    endfunction

    function automatic logic [7:0] bad_type();
        case ($urandom_range(0, 2))
            0:       return pngunf_pkg::FILT_CODE_MAX + 8'd1;
            1:       return 8'hFF;
            default: return 8'($urandom_range(pngunf_pkg::FILT_CODE_MAX + 1, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: %0t ns: %s", $time, msg);
        err_count++;
    endtask

    task automatic send_byte(input logic sof, input logic [7:0] code, input bit typed = 1'b0,
                             input bit typed_has = 1'b0,
                             input pngunf_pkg::out_item_t typed_res = '0);
        int unsigned           gap;
        bit                    has;
        pngunf_pkg::out_item_t r;
        pngunf_pkg::in_item_t  it;
        it.filtered_byte  = code;
        it.start_of_frame = sof;
        gap = src_burst ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_recon(it, has, r);
        if (typed) begin
            has = typed_has;
            r   = typed_res;
        end
        if (has) recon_q.push_back(r);
        sent_count++;
    endtask

    // Called right after a transfer, so valid is dropped before the next edge.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (recon_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        width_reg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One frame: full rows, then an optional partial row. With noise enabled,
    // bad type bytes, ignored bytes and restarts in mid-row are mixed in.
    task automatic gen_frame(input int unsigned rows, input int unsigned tail, input bit noisy);
        int unsigned w;
        int unsigned nbytes;
        w = eff_w(width_reg);
        for (int unsigned r = 0; r <= rows; r++) begin
            nbytes = (r < rows) ? PIX_BYTES * w : tail;
            if (r == rows && tail == 0) break;
            if (noisy && $urandom_range(0, 15) == 0) begin
                send_byte(r == 0, bad_type());
                repeat ($urandom_range(0, 4)) send_byte(1'b0, rnd_byte());
                return;
            end
            send_byte(r == 0, good_type());
            for (int unsigned i = 0; i < nbytes; i++) begin
                if (noisy && $urandom_range(0, 299) == 0) begin
                    send_byte(1'b1, good_type());
                    return;
                end
                send_byte(1'b0, rnd_byte());
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold when requested.
    initial begin
        int unsigned stall_left;
        bit          hold_taken;
        m_ready    = 1'b0;
        stall_left = 0;
        hold_taken = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_now && !hold_taken) begin
                stall_left = 400;
                hold_taken = 1'b1;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = sink_burst ? 0 : pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        pngunf_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (recon_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0h", m_data));
            end else begin
                want = recon_q.pop_front();
                if (m_data.recon_byte !== want.recon_byte)
                    report_mismatch($sformatf("recon_byte %0h, expected %0h",
                                              m_data.recon_byte, want.recon_byte));
                if (m_data.last_in_row !== want.last_in_row)
                    report_mismatch($sformatf("last_in_row %0b, expected %0b",
                                              m_data.last_in_row, want.last_in_row));
                if (m_data.bad_filter !== want.bad_filter)
                    report_mismatch($sformatf("bad_filter %0b, expected %0b",
                                              m_data.bad_filter, want.bad_filter));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int phase_w [12];
        int unsigned w;
        int unsigned start;
        phase_w    = '{0, 1, 2, 3, 4095, 5, 8, 2048, 13, -1, -1, 1};
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_data     = '0;
        sent_count = 0;
        src_burst  = 1'b0;
        sink_burst = 1'b0;
        hold_now   = 1'b0;
        col        = 0;
        chan       = 0;
        row_kind   = pngunf_pkg::FILT_NONE;
        want_type  = 1'b1;
        first_row  = 1'b1;
        halted_st  = 1'b0;
        width_reg  = 1;
        for (int i = 0; i < PIX_BYTES; i++) begin
            left_px[i] = 8'h00;
            ul_px[i]   = 8'h00;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i])
            send_byte(dir_tab[i].sof, dir_tab[i].code, dir_tab[i].typed,
                      dir_tab[i].has_res, dir_tab[i].res);
        wait_idle();

        foreach (phase_w[p]) begin
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            write_width(CFG_W'(phase_w[p] < 0 ? $urandom_range(1, 20) : phase_w[p]));
            w = eff_w(width_reg);
            if (w > 100) begin
                // A full row at the widest settings is far too long, so only
                // the start of a first row is sent.
                gen_frame(0, (phase_w[p] > MAX_W) ? 12 : 40, 1'b0);
            end else begin
                if (p == 2) begin
                    // Keep offering bytes while the receiver holds off.
                    src_burst = 1'b1;
                    hold_now  = 1'b1;
                end
                start = sent_count;
                while (sent_count - start < SMALL_BUDGET)
                    gen_frame($urandom_range(1, 3), $urandom_range(0, PIX_BYTES * w - 1), 1'b1);
            end
            wait_idle();
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pngunf_pkg.sv
sv/pngunf_front.sv
sv/pngunf_queue.sv
sv/pngunf_back.sv
sv/png_scanline_unfilter.sv
tb/sv/tb_png_scanline_unfilter.sv
